/* rtl/tmnm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tmnm_pkg
// shared constants, transaction types and fixed point helpers for the
// model and normal matrix block
// ----------------------------------------------------------------------------
package tmnm_pkg;

  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned ANGLE_BITS = 16;

  // taylor terms after the leading one
  localparam int unsigned TERMS = 10;

  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // sine/cosine pipeline: angle scale, square, three stages a term, clamp, quadrant
  localparam int unsigned SC_LAT = 3 * TERMS + 4;
  // reciprocal: setup, one stage a quotient bit, saturate
  localparam int unsigned NUM_W  = (2 * FRAC_BITS + 1 > 32) ? 2 * FRAC_BITS + 1 : 32;
  localparam int unsigned RC_LAT = NUM_W + 2;
  localparam int unsigned A_LAT  = (SC_LAT > RC_LAT) ? SC_LAT : RC_LAT;

  localparam logic       KIND_MODEL  = 1'b0;
  localparam logic       KIND_NORMAL = 1'b1;
  localparam logic [1:0] COL_TRANS   = 2'd3;
  localparam int unsigned NUM_COLS   = 7;

  typedef struct packed {
    logic signed [31:0] move_x;
    logic signed [31:0] move_y;
    logic signed [31:0] move_z;
    logic [15:0]        angle_x;
    logic [15:0]        angle_y;
    logic [15:0]        angle_z;
    logic signed [31:0] size_x;
    logic signed [31:0] size_y;
    logic signed [31:0] size_z;
  } in_t;

  typedef struct packed {
    logic               matrix_kind;
    logic [1:0]         column_index;
    logic signed [31:0] elem_x;
    logic signed [31:0] elem_y;
    logic signed [31:0] elem_z;
    logic               clipped;
    logic               last_column;
  } out_t;

  typedef struct packed {
    logic               clip;
    logic signed [31:0] val;
  } sat_t;

  // round(a*b / 2^30), half away from zero
  function automatic logic signed [36:0] mul30(input logic signed [33:0] a,
                                                input logic signed [33:0] b);
    logic [33:0] ma;
    logic [33:0] mb;
    logic [67:0] p;
    logic [36:0] r;
    ma = a[33] ? 34'(-a) : 34'(a);
    mb = b[33] ? 34'(-b) : 34'(b);
    p  = 68'(ma) * 68'(mb) + (68'(1) << 29);
    r  = p[66:30];
    mul30 = (a[33] ^ b[33]) ? -$signed(r) : $signed(r);
  endfunction

  function automatic sat_t sat32(input logic signed [36:0] v);
    sat_t s;
    if (v > 37'sd2147483647) begin
      s.clip = 1'b1;
      s.val  = 32'sh7FFF_FFFF;
    end else if (v < -37'sd2147483648) begin
      s.clip = 1'b1;
      s.val  = 32'sh8000_0000;
    end else begin
      s.clip = 1'b0;
      s.val  = 32'(v);
    end
    sat32 = s;
  endfunction

endpackage
`default_nettype wire

/* rtl/trs_model_and_normal_matrix_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// trs_model_and_normal_matrix_top
// model matrix and normal matrix from translation, euler angles and scale
// ----------------------------------------------------------------------------
// usage
//   input channel: one transaction carries move, angle and size of one object
//   output channel: seven transactions per input, in order: model columns
//   0..2 (rotation times scale), model column 3 (translation), normal
//   columns 0..2 (rotation times reciprocal scale, last one flagged)
//   path to the first column: the 35 stage reciprocal pipeline
//   (sine/cosine is 34 stages plus one alignment stage), two
//   rotation stages, one product stage and the column buffer
//   throughput: set by the output channel carrying seven columns per
//   input, one column per cycle while out_stall_i is low; inputs enter
//   the pipeline in any cycle it moves
//   the whole pipeline moves on one enable; it holds only when its last
//   stage is full and the column buffer cannot take it, so a stalled
//   receiver freezes everything without loss and back-pressures the input
//   reset clears the valid bits and the column buffer state, data regs
//   are left as they are
// ----------------------------------------------------------------------------
module trs_model_and_normal_matrix_top import tmnm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int unsigned TOT    = A_LAT + 3;
  localparam int unsigned SC_DLY = A_LAT - SC_LAT;
  localparam int unsigned RC_DLY = A_LAT - RC_LAT;
  localparam logic [2:0]  LAST_COL = 3'(NUM_COLS - 1);

  typedef struct packed {
    logic signed [31:0] s1, c1, s2, c2, s3, c3;
  } trig_t;

  typedef struct packed {
    logic [2:0][31:0] inv;
    logic [2:0]       clip;
  } recip_t;

  typedef struct packed {
    in_t                item;
    recip_t             rcp;
    logic signed [33:0] c1c3, s1s2, c2s3, c1s2, c3s1, c1s3, c2c3, s1s3, c2s1, c1c2;
    logic signed [33:0] s2, s3;
  } r1_t;

  typedef struct packed {
    in_t                   item;
    recip_t                rcp;
    logic [2:0][2:0][33:0] rot;
  } r2_t;

  typedef struct packed {
    in_t                   item;
    logic [2:0]            iclip;
    logic [2:0][2:0][36:0] pm;
    logic [2:0][2:0][36:0] pn;
  } e1_t;

  logic           adv;
  logic [TOT-1:0] vld_q;
  logic           ser_take;
  logic           out_fire;
  logic           ser_busy_q;
  logic [2:0]     cnt_q;

  trig_t  trig_raw, trig_a;
  recip_t rcp_raw, rcp_a;
  in_t    item_q [A_LAT];
  r1_t    r1_q;
  r2_t    r2_q;
  e1_t    e1_q;
  out_t   cols_d [NUM_COLS];
  out_t   cols_q [NUM_COLS];

  // whole pipeline moves together
  assign out_fire   = ser_busy_q && !out_stall_i;
  assign ser_take   = vld_q[TOT-1] && (!ser_busy_q || (out_fire && cnt_q == LAST_COL));
  assign adv        = !vld_q[TOT-1] || ser_take;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[TOT-2:0], in_valid_i};
    end
  end

  // angle y, then x, then z
  tmnm_sincos u_sc_y (.clk_i, .en_i(adv), .angle_i(in_data_i.angle_y),
                      .sin_o(trig_raw.s1), .cos_o(trig_raw.c1));
  tmnm_sincos u_sc_x (.clk_i, .en_i(adv), .angle_i(in_data_i.angle_x),
                      .sin_o(trig_raw.s2), .cos_o(trig_raw.c2));
  tmnm_sincos u_sc_z (.clk_i, .en_i(adv), .angle_i(in_data_i.angle_z),
                      .sin_o(trig_raw.s3), .cos_o(trig_raw.c3));

  logic signed [31:0] inv_x, inv_y, inv_z;

  tmnm_recip u_rc_x (.clk_i, .en_i(adv), .size_i(in_data_i.size_x),
                     .inv_o(inv_x), .clip_o(rcp_raw.clip[0]));
  tmnm_recip u_rc_y (.clk_i, .en_i(adv), .size_i(in_data_i.size_y),
                     .inv_o(inv_y), .clip_o(rcp_raw.clip[1]));
  tmnm_recip u_rc_z (.clk_i, .en_i(adv), .size_i(in_data_i.size_z),
                     .inv_o(inv_z), .clip_o(rcp_raw.clip[2]));

  assign rcp_raw.inv[0] = inv_x;
  assign rcp_raw.inv[1] = inv_y;
  assign rcp_raw.inv[2] = inv_z;

  // line up the two arithmetic paths
  if (SC_DLY == 0) begin : g_sc_nodly
    assign trig_a = trig_raw;
  end else begin : g_sc_dly
    trig_t dly_q [SC_DLY];
    always_ff @(posedge clk_i) begin
      if (adv) dly_q[0] <= trig_raw;
    end
    for (genvar i = 1; i < SC_DLY; i++) begin : g_tap
      always_ff @(posedge clk_i) begin
        if (adv) dly_q[i] <= dly_q[i-1];
      end
    end
    assign trig_a = dly_q[SC_DLY-1];
  end

  if (RC_DLY == 0) begin : g_rc_nodly
    assign rcp_a = rcp_raw;
  end else begin : g_rc_dly
    recip_t dly_q [RC_DLY];
    always_ff @(posedge clk_i) begin
      if (adv) dly_q[0] <= rcp_raw;
    end
    for (genvar i = 1; i < RC_DLY; i++) begin : g_tap
      always_ff @(posedge clk_i) begin
        if (adv) dly_q[i] <= dly_q[i-1];
      end
    end
    assign rcp_a = dly_q[RC_DLY-1];
  end

  // raw transaction rides alongside
  always_ff @(posedge clk_i) begin
    if (adv) item_q[0] <= in_data_i;
  end
  for (genvar i = 1; i < A_LAT; i++) begin : g_item
    always_ff @(posedge clk_i) begin
      if (adv) item_q[i] <= item_q[i-1];
    end
  end

  // rotation pairs
  always_ff @(posedge clk_i) begin
    if (adv) begin
      r1_q.item <= item_q[A_LAT-1];
      r1_q.rcp  <= rcp_a;
      r1_q.c1c3 <= 34'(mul30(34'(trig_a.c1), 34'(trig_a.c3)));
      r1_q.s1s2 <= 34'(mul30(34'(trig_a.s1), 34'(trig_a.s2)));
      r1_q.c2s3 <= 34'(mul30(34'(trig_a.c2), 34'(trig_a.s3)));
      r1_q.c1s2 <= 34'(mul30(34'(trig_a.c1), 34'(trig_a.s2)));
      r1_q.c3s1 <= 34'(mul30(34'(trig_a.c3), 34'(trig_a.s1)));
      r1_q.c1s3 <= 34'(mul30(34'(trig_a.c1), 34'(trig_a.s3)));
      r1_q.c2c3 <= 34'(mul30(34'(trig_a.c2), 34'(trig_a.c3)));
      r1_q.s1s3 <= 34'(mul30(34'(trig_a.s1), 34'(trig_a.s3)));
      r1_q.c2s1 <= 34'(mul30(34'(trig_a.c2), 34'(trig_a.s1)));
      r1_q.c1c2 <= 34'(mul30(34'(trig_a.c1), 34'(trig_a.c2)));
      r1_q.s2   <= 34'(trig_a.s2);
      r1_q.s3   <= 34'(trig_a.s3);
    end
  end

  // triple products and sums, rot[col][row]
  always_ff @(posedge clk_i) begin
    if (adv) begin
      r2_q.item      <= r1_q.item;
      r2_q.rcp       <= r1_q.rcp;
      r2_q.rot[0][0] <= r1_q.c1c3 + 34'(mul30(r1_q.s1s2, r1_q.s3));
      r2_q.rot[0][1] <= r1_q.c2s3;
      r2_q.rot[0][2] <= 34'(mul30(r1_q.c1s2, r1_q.s3)) - r1_q.c3s1;
      r2_q.rot[1][0] <= 34'(mul30(r1_q.c3s1, r1_q.s2)) - r1_q.c1s3;
      r2_q.rot[1][1] <= r1_q.c2c3;
      r2_q.rot[1][2] <= 34'(mul30(r1_q.c1c3, r1_q.s2)) + r1_q.s1s3;
      r2_q.rot[2][0] <= r1_q.c2s1;
      r2_q.rot[2][1] <= -r1_q.s2;
      r2_q.rot[2][2] <= r1_q.c1c2;
    end
  end

  // scale and reciprocal scale products
  logic [2:0][31:0] size_v;
  assign size_v[0] = r2_q.item.size_x;
  assign size_v[1] = r2_q.item.size_y;
  assign size_v[2] = r2_q.item.size_z;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e1_q.item  <= r2_q.item;
      e1_q.iclip <= r2_q.rcp.clip;
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          e1_q.pm[c][r] <= mul30(34'($signed(size_v[c])), $signed(r2_q.rot[c][r]));
          e1_q.pn[c][r] <= mul30(34'($signed(r2_q.rcp.inv[c])), $signed(r2_q.rot[c][r]));
        end
      end
    end
  end

  // saturate and lay out the seven columns
  always_comb begin
    sat_t sm [3];
    sat_t sn [3];
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        sm[r] = sat32($signed(e1_q.pm[c][r]));
        sn[r] = sat32($signed(e1_q.pn[c][r]));
      end
      cols_d[c].matrix_kind  = KIND_MODEL;
      cols_d[c].column_index = 2'(c);
      cols_d[c].elem_x       = sm[0].val;
      cols_d[c].elem_y       = sm[1].val;
      cols_d[c].elem_z       = sm[2].val;
      cols_d[c].clipped      = sm[0].clip | sm[1].clip | sm[2].clip;
      cols_d[c].last_column  = 1'b0;
      cols_d[4+c].matrix_kind  = KIND_NORMAL;
      cols_d[4+c].column_index = 2'(c);
      cols_d[4+c].elem_x       = sn[0].val;
      cols_d[4+c].elem_y       = sn[1].val;
      cols_d[4+c].elem_z       = sn[2].val;
      cols_d[4+c].clipped      = e1_q.iclip[c] | sn[0].clip | sn[1].clip | sn[2].clip;
      cols_d[4+c].last_column  = (c == 2);
    end
    cols_d[3].matrix_kind  = KIND_MODEL;
    cols_d[3].column_index = COL_TRANS;
    cols_d[3].elem_x       = e1_q.item.move_x;
    cols_d[3].elem_y       = e1_q.item.move_y;
    cols_d[3].elem_z       = e1_q.item.move_z;
    cols_d[3].clipped      = 1'b0;
    cols_d[3].last_column  = 1'b0;
  end

  // column buffer, one output transaction a cycle while the receiver does not stall
  always_ff @(posedge clk_i) begin
    if (ser_take) cols_q <= cols_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_busy_q <= 1'b0;
      cnt_q      <= '0;
    end else if (ser_take) begin
      ser_busy_q <= 1'b1;
      cnt_q      <= '0;
    end else if (out_fire) begin
      if (cnt_q == LAST_COL) begin
        ser_busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 3'd1;
      end
    end
  end

  assign out_valid_o = ser_busy_q;
  assign out_data_o  = cols_q[cnt_q];

endmodule
`default_nettype wire

/* rtl/tmnm_sincos.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tmnm_sincos
// pipelined sine and cosine of a turn fraction, q30 taylor series
// ----------------------------------------------------------------------------
module tmnm_sincos import tmnm_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [15:0]        angle_i,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  localparam int unsigned RW = ANGLE_BITS - 2;
  localparam int unsigned PW = RW + 32;

  typedef struct packed {
    logic [1:0]         quad;
    logic [31:0]        x2;
    logic [33:0]        ts;
    logic [33:0]        tc;
    logic [33:0]        qs;
    logic [33:0]        qc;
    logic signed [35:0] ss;
    logic signed [35:0] cc;
  } sc_t;

  logic [ANGLE_BITS-1:0] ang;
  logic [PW-1:0]         xprod;
  logic [30:0]           x_q;
  logic [1:0]            quad_q;
  logic [62:0]           xsq;

  sc_t term_q [TERMS+1];
  sc_t a_q    [TERMS];
  sc_t b_q    [TERMS];

  logic [30:0] sc_q;
  logic [30:0] cc_q;
  logic [1:0]  qd_q;

  assign ang   = ANGLE_BITS'(angle_i);
  assign xprod = PW'(ang[RW-1:0]) * PW'(PI_Q30);
  assign xsq   = 63'(x_q) * 63'(x_q) + (63'(1) << 29);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= xprod[ANGLE_BITS-1 +: 31];
      quad_q <= ang[ANGLE_BITS-1 -: 2];
      term_q[0].quad <= quad_q;
      term_q[0].x2   <= xsq[61:30];
      term_q[0].ts   <= 34'(x_q);
      term_q[0].tc   <= 34'(ONE_Q30);
      term_q[0].qs   <= '0;
      term_q[0].qc   <= '0;
      term_q[0].ss   <= $signed(36'(x_q));
      term_q[0].cc   <= $signed(36'(ONE_Q30));
    end
  end

  for (genvar n = 0; n < TERMS; n++) begin : g_term
    localparam longint unsigned K  = 2 * (n + 1);
    localparam longint unsigned DS = K * (K + 1);
    localparam longint unsigned DC = (K - 1) * K;
    localparam logic [34:0] MS = 35'((64'd1 << 34) / DS);
    localparam logic [34:0] MC = 35'((64'd1 << 34) / DC);
    localparam bit SUB = (n % 2 == 0);

    logic [65:0] ps, pc;
    logic [68:0] bs, bc;
    logic [33:0] rs, rc, ns, nc;
    sc_t         a_d, b_d, t_d;

    // term times x^2, rounded back to q30
    assign ps = 66'(term_q[n].ts) * 66'(term_q[n].x2) + (66'(1) << 29);
    assign pc = 66'(term_q[n].tc) * 66'(term_q[n].x2) + (66'(1) << 29);
    // quotient estimate by reciprocal, at most one short
    assign bs = 69'(a_q[n].ts) * 69'(MS);
    assign bc = 69'(a_q[n].tc) * 69'(MC);
    assign rs = b_q[n].ts - 34'(b_q[n].qs * 34'(DS));
    assign rc = b_q[n].tc - 34'(b_q[n].qc * 34'(DC));
    assign ns = b_q[n].qs + 34'(rs >= 34'(DS));
    assign nc = b_q[n].qc + 34'(rc >= 34'(DC));

    always_comb begin
      a_d    = term_q[n];
      a_d.ts = ps[63:30];
      a_d.tc = pc[63:30];
      b_d    = a_q[n];
      b_d.qs = bs[67:34];
      b_d.qc = bc[67:34];
      t_d    = b_q[n];
      t_d.ts = ns;
      t_d.tc = nc;
      if (SUB) begin
        t_d.ss = b_q[n].ss - $signed({2'b00, ns});
        t_d.cc = b_q[n].cc - $signed({2'b00, nc});
      end else begin
        t_d.ss = b_q[n].ss + $signed({2'b00, ns});
        t_d.cc = b_q[n].cc + $signed({2'b00, nc});
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q[n]      <= a_d;
        b_q[n]      <= b_d;
        term_q[n+1] <= t_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qd_q <= term_q[TERMS].quad;
      if (term_q[TERMS].ss < 0) begin
        sc_q <= '0;
      end else if (term_q[TERMS].ss > 36'sh4000_0000) begin
        sc_q <= ONE_Q30;
      end else begin
        sc_q <= term_q[TERMS].ss[30:0];
      end
      if (term_q[TERMS].cc < 0) begin
        cc_q <= '0;
      end else if (term_q[TERMS].cc > 36'sh4000_0000) begin
        cc_q <= ONE_Q30;
      end else begin
        cc_q <= term_q[TERMS].cc[30:0];
      end
    end
  end

  // quadrant fold
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      case (qd_q)
        2'd0: begin
          sin_o <= $signed(32'(sc_q));
          cos_o <= $signed(32'(cc_q));
        end
        2'd1: begin
          sin_o <= $signed(32'(cc_q));
          cos_o <= -$signed(32'(sc_q));
        end
        2'd2: begin
          sin_o <= -$signed(32'(sc_q));
          cos_o <= -$signed(32'(cc_q));
        end
        default: begin
          sin_o <= -$signed(32'(cc_q));
          cos_o <= $signed(32'(sc_q));
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/tmnm_recip.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tmnm_recip
// pipelined restoring divider for the saturated reciprocal of a scale
// ----------------------------------------------------------------------------
module tmnm_recip import tmnm_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] size_i,
  output logic signed [31:0] inv_o,
  output logic               clip_o
);

  typedef struct packed {
    logic [31:0]      m;
    logic             neg;
    logic             zero;
    logic [31:0]      rem;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] quo;
  } div_t;

  div_t        dv_q [NUM_W+1];
  logic [31:0] mag;

  assign mag = size_i[31] ? 32'(-size_i) : 32'(size_i);

  // numerator is 2^(2f) plus half the divisor, for rounding
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_q[0].m    <= mag;
      dv_q[0].neg  <= size_i[31];
      dv_q[0].zero <= (size_i == 32'sd0);
      dv_q[0].rem  <= '0;
      dv_q[0].num  <= (NUM_W'(1) << (2 * FRAC_BITS)) + NUM_W'(mag >> 1);
      dv_q[0].quo  <= '0;
    end
  end

  for (genvar i = 0; i < NUM_W; i++) begin : g_bit
    logic [32:0] trial;
    logic        take;
    div_t        dv_d;

    assign trial = {dv_q[i].rem, dv_q[i].num[NUM_W-1]};
    assign take  = (trial >= {1'b0, dv_q[i].m});

    always_comb begin
      dv_d     = dv_q[i];
      dv_d.rem = take ? 32'(trial - {1'b0, dv_q[i].m}) : trial[31:0];
      dv_d.num = dv_q[i].num << 1;
      dv_d.quo = {dv_q[i].quo[NUM_W-2:0], take};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_q[i+1] <= dv_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (dv_q[NUM_W].zero) begin
        inv_o  <= 32'sh7FFF_FFFF;
        clip_o <= 1'b1;
      end else if (!dv_q[NUM_W].neg) begin
        if (dv_q[NUM_W].quo > NUM_W'(32'h7FFF_FFFF)) begin
          inv_o  <= 32'sh7FFF_FFFF;
          clip_o <= 1'b1;
        end else begin
          inv_o  <= $signed(dv_q[NUM_W].quo[31:0]);
          clip_o <= 1'b0;
        end
      end else begin
        if (dv_q[NUM_W].quo > NUM_W'(32'h8000_0000)) begin
          inv_o  <= 32'sh8000_0000;
          clip_o <= 1'b1;
        end else begin
          inv_o  <= -$signed(dv_q[NUM_W].quo[31:0]);
          clip_o <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire
